FILE: hdl/gsd_pkg.sv
// gsd_pkg: shared types, character codes and checksum helpers for the
// sentence deframer. No dependencies; used by gsd_framer and the top level.

package gsd_pkg;

    // Default bound on frame length, start byte included
    localparam int MAX_FRAME_LEN_DEF = 256;

    // Width of the frame length on the result port
    localparam int LEN_W = 9;

    // Character codes
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_F   = 8'h46;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_F   = 8'h66;

    // Reflected CRC-32 polynomial
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    // Protocol codes
    localparam logic PROTO_NMEA = 1'b0;
    localparam logic PROTO_LOG  = 1'b1;

    // Check digits per frame, modulo 8 as the digit counter wraps
    localparam logic [2:0] DIGITS_NMEA = 3'd2;
    localparam logic [2:0] DIGITS_LOG  = 3'd0;

    // One finished frame, as handed from the framer to the output register
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] length;
        logic             protocol;
        logic             passed;
    } gsd_result_t;

    // Fold one byte into the reflected CRC-32, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'h000000, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

    // Hex digit value; bit 4 flags a character that is not a valid digit
    function automatic logic [4:0] hex_value(input logic [7:0] c,
                                             input logic       lower_ok);
        logic [4:0] v;
        v = 5'h10;
        if (c >= CHAR_0 && c <= CHAR_9)
            v = {1'b0, 4'(c - CHAR_0)};
        else if (c >= CHAR_UC_A && c <= CHAR_UC_F)
            v = {1'b0, 4'(c - CHAR_UC_A + 8'd10)};
        else if (lower_ok && c >= CHAR_LC_A && c <= CHAR_LC_F)
            v = {1'b0, 4'(c - CHAR_LC_A + 8'd10)};
        return v;
    endfunction

endpackage

FILE: hdl/gsd_framer.sv
// gsd_framer: sentence framing state, running XOR and CRC-32, check digit
// capture and the frame verdict. Depends on gsd_pkg.

module gsd_framer #(
    parameter int MAX_FRAME_LEN = gsd_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    output gsd_pkg::gsd_result_t result
);

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_LEN);

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_BODY   = 3'd1,
        ST_DIGITS = 3'd2
    } state_t;

    state_t             state_reg,  state_next;
    logic               proto_reg,  proto_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [2:0]         digits_reg, digits_next;
    logic [7:0]         xor_reg,    xor_next;
    logic [31:0]        crc_reg,    crc_next;
    logic [31:0]        check_reg,  check_next;
    logic               derr_reg,   derr_next;

    logic               is_start;
    logic [4:0]         hex;
    logic [2:0]         need;
    logic               pass;
    logic [CNT_W+8:0]   count_wide;

    assign is_start = (rx_byte == gsd_pkg::CHAR_DOLLAR) || (rx_byte == gsd_pkg::CHAR_HASH);
    assign hex      = gsd_pkg::hex_value(rx_byte, proto_reg);
    assign need     = proto_reg ? gsd_pkg::DIGITS_LOG : gsd_pkg::DIGITS_NMEA;

    // Work out the next framing state and any verdict for this byte
    always_comb
    begin
        state_next  = state_reg;
        proto_next  = proto_reg;
        count_next  = count_reg;
        digits_next = digits_reg;
        xor_next    = xor_reg;
        crc_next    = crc_reg;
        check_next  = check_reg;
        derr_next   = derr_reg;
        pass        = 1'b0;
        count_wide  = '0;
        result      = '0;

        if (state_reg == ST_HUNT || (state_reg == ST_BODY && is_start) ||
            (state_reg != ST_BODY && state_reg != ST_DIGITS)) begin
            // hunt for a start byte, or resync on one seen in the body
            state_next = ST_HUNT;
            if (is_start)
            begin
                state_next  = ST_BODY;
                proto_next  = (rx_byte == gsd_pkg::CHAR_HASH) ? gsd_pkg::PROTO_LOG
                                                              : gsd_pkg::PROTO_NMEA;
                count_next  = CNT_W'(1);
                digits_next = 3'd0;
                xor_next    = 8'h00;
                crc_next    = 32'h0;
                check_next  = 32'h0;
                derr_next   = 1'b0;
            end
        end else if (count_reg >= MAX_CNT) begin
            // drop an overlong frame without a verdict
            state_next  = ST_HUNT;
            count_next  = '0;
            digits_next = 3'd0;
        end else begin
            count_next = count_reg + CNT_W'(1);
            if (state_reg == ST_BODY)
            begin
                if (rx_byte == gsd_pkg::CHAR_STAR)
                begin
                    state_next  = ST_DIGITS;
                    digits_next = 3'd0;
                    check_next  = 32'h0;
                    derr_next   = 1'b0;
                end else begin
                    xor_next = xor_reg ^ rx_byte;
                    crc_next = gsd_pkg::crc_byte(crc_reg, rx_byte);
                end
            end else begin
                // shift in one check digit; a bad digit counts as zero
                derr_next   = derr_reg | hex[4];
                check_next  = {check_reg[27:0], (hex[4] ? 4'h0 : hex[3:0])};
                digits_next = digits_reg + 3'd1;
                if (digits_next == need)
                begin
                    if (proto_reg)
                        pass = (check_next == crc_reg);
                    else
                        pass = (check_next[7:0] == xor_reg);
                    count_wide      = {9'd0, count_next};
                    result.valid    = 1'b1;
                    result.length   = count_wide[gsd_pkg::LEN_W-1:0];
                    result.protocol = proto_reg;
                    result.passed   = pass && !derr_next;
                    state_next      = ST_HUNT;
                    count_next      = '0;
                    digits_next     = 3'd0;
                end
            end
        end
    end

    // Hold framing state between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HUNT;
            proto_reg  <= 1'b0;
            count_reg  <= '0;
            digits_reg <= 3'd0;
            xor_reg    <= 8'h00;
            crc_reg    <= 32'h0;
            check_reg  <= 32'h0;
            derr_reg   <= 1'b0;
        end else if (step) begin
            state_reg  <= state_next;
            proto_reg  <= proto_next;
            count_reg  <= count_next;
            digits_reg <= digits_next;
            xor_reg    <= xor_next;
            crc_reg    <= crc_next;
            check_reg  <= check_next;
            derr_reg   <= derr_next;
        end
    end

    // A verdict always closes the frame and returns to hunting
    a_verdict_closes: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.valid |=> state_reg == ST_HUNT && count_reg == '0)
        else $error("framer did not return to hunting after a verdict");

    // A verdict only comes out of the check digit phase
    a_verdict_in_digits: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> state_reg == ST_DIGITS)
        else $error("verdict outside check digit phase");

    // The frame counter never passes the length bound
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("frame byte count beyond bound");

    // A start byte in the body restarts the frame
    a_resync: assert property (@(posedge clk) disable iff (!rst_n)
        step && state_reg == ST_BODY && is_start
        |=> state_reg == ST_BODY && count_reg == CNT_W'(1))
        else $error("no resync on start byte in body");

endmodule

FILE: hdl/gnss_sentence_deframer.sv
// gnss_sentence_deframer: top level; input byte register, framer and
// result register with valid/stall handshakes. Depends on gsd_pkg, gsd_framer.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid, in_stall  | rx_byte[7:0]
//  output   | out_valid, out_stall| frame_length[8:0], frame_protocol,
//           |                     | check_passed
//
// One byte per cycle sustained while no verdict waits under out_stall; a byte
// is held in the byte register and framed by the framer step, and its verdict,
// if any, is loaded into the result register before it appears on the output.
// Reset clears all framing state; no clearing pass is needed.
// While a verdict waits under out_stall, the byte register takes at most one
// more byte and holds it; in_stall stays high until the output is taken.

module gnss_sentence_deframer #(
    parameter int MAX_FRAME_LEN = gsd_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [gsd_pkg::LEN_W-1:0] frame_length,
    output logic                      frame_protocol,
    output logic                      check_passed
);

    logic                      in_full_reg,  in_full_next;
    logic [7:0]                byte_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [gsd_pkg::LEN_W-1:0] length_reg;
    logic                      protocol_reg;
    logic                      passed_reg;
    logic                      advance;
    logic                      in_take;
    gsd_pkg::gsd_result_t      result;

    // Move the held byte through the framer when the output can take a result
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    gsd_framer #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (byte_reg),
        .result  (result)
    );

    // Track occupancy of the byte register and the result register
    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = result.valid;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // Hold handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payload registers on transfer
    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= rx_byte;
        if (advance && result.valid)
        begin
            length_reg   <= result.length;
            protocol_reg <= result.protocol;
            passed_reg   <= result.passed;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_length   = length_reg;
    assign frame_protocol = protocol_reg;
    assign check_passed   = passed_reg;

endmodule
